>>> rtl/scb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scb_pkg
// Shared types, widths and codes for the sprite cell blitter.
// ----------------------------------------------------------------------------
package scb_pkg;

  // Defaults for the top-level parameters
  localparam int SHEET_WORDS_DEF    = 65536;
  localparam int MAX_TARGET_DIM_DEF = 2048;

  // Integer zoom ceiling
  localparam int MAX_SCALE = 8;

  // Field widths
  localparam int ACT_W   = 2;
  localparam int SADDR_W = 16;
  localparam int PIX_W   = 24;
  localparam int SHT_W   = 9;   // sheet and cell dimensions
  localparam int IDX_W   = 16;  // cell index
  localparam int VPOS_W  = 12;  // view position
  localparam int TGT_W   = 12;  // target dimensions
  localparam int SCL_W   = 4;   // pixel scale
  localparam int TADDR_W = 22;
  localparam int COLOR_W = 32;
  localparam int STAT_W  = 2;

  // Derived internal widths
  localparam int SPOS_W = SHT_W + 1;                           // source pixel coordinate
  localparam int LIN_W  = 21;                                  // linear sheet address
  localparam int PROD_W = 2 * SHT_W;                           // cols * rows
  localparam int CRD_W  = VPOS_W + 2 + $clog2(MAX_SCALE + 1);  // signed target coordinate
  localparam int DCNT_W = $clog2(IDX_W);                       // divider step counter

  // Configuration port
  localparam int APB_DW = 32;
  localparam int REG_AW = 5;
  localparam int REG_IW = REG_AW - 2;

  localparam logic [REG_IW-1:0] REG_SHEET_W  = 3'd0;
  localparam logic [REG_IW-1:0] REG_SHEET_H  = 3'd1;
  localparam logic [REG_IW-1:0] REG_TARGET_W = 3'd2;
  localparam logic [REG_IW-1:0] REG_TARGET_H = 3'd3;
  localparam logic [REG_IW-1:0] REG_SCALE    = 3'd4;

  localparam logic [SHT_W-1:0] SHEET_W_RST  = 9'd256;
  localparam logic [SHT_W-1:0] SHEET_H_RST  = 9'd256;
  localparam logic [TGT_W-1:0] TARGET_W_RST = 12'd1280;
  localparam logic [TGT_W-1:0] TARGET_H_RST = 12'd720;
  localparam logic [SCL_W-1:0] SCALE_RST    = 4'd1;

  // Request actions
  localparam logic [ACT_W-1:0] ACT_LOAD    = 2'd0;
  localparam logic [ACT_W-1:0] ACT_START   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_ADVANCE = 2'd2;

  // Result status
  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_REJECT  = 2'd1;
  localparam logic [STAT_W-1:0] ST_NO_CELL = 2'd2;

  localparam logic [COLOR_W-1:0] ALPHA_OPAQUE = 32'hFF00_0000;

  // Sequencer states
  typedef enum logic [10:0] {
    S_IDLE = 11'b000_0000_0001,
    S_DIVW = 11'b000_0000_0010,
    S_DIVH = 11'b000_0000_0100,
    S_CHK  = 11'b000_0000_1000,
    S_CHK2 = 11'b000_0001_0000,
    S_DIVI = 11'b000_0010_0000,
    S_ORG  = 11'b000_0100_0000,
    S_ADDR = 11'b000_1000_0000,
    S_READ = 11'b001_0000_0000,
    S_DATA = 11'b010_0000_0000,
    S_EMIT = 11'b100_0000_0000
  } state_t;

endpackage

>>> rtl/scb_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scb_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module scb_ram #(
  parameter  int WIDTH = 24,
  parameter  int DEPTH = 256,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/sprite_cell_blitter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprite_cell_blitter
// Draws one cell of a stored sprite sheet into a target frame buffer.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on start/action with busy low. A load writes one sheet
//   pixel into the sheet RAM in the accepting cycle and gives no result.
//   A start finds the cell on the sheet with a shared radix-2 divider
//   (sheet_width/frame_width, sheet_height/frame_height, index/columns)
//   plus check and commit states and gives one result. A start with a
//   zero dimension answers in the next cycle. An advance looks up the
//   pixel in S_ADDR, S_READ and S_DATA (the sheet RAM read and two
//   multiply stages) and then sends its clipped pixel_scale square at
//   one write per cycle; a pixel with nothing to write gives one result.
//   Results appear on result_strobe for exactly one cycle each; last marks
//   the final result of a request. The receiver cannot stall the block.
//   Configuration must be written over APB only while the block is idle;
//   the block does not enforce it. Reset clears the walk state and registers;
//   the sheet RAM keeps its contents and an entry is undefined until loaded.
// ----------------------------------------------------------------------------
module sprite_cell_blitter #(
  parameter int SHEET_WORDS    = scb_pkg::SHEET_WORDS_DEF,
  parameter int MAX_TARGET_DIM = scb_pkg::MAX_TARGET_DIM_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // Configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [scb_pkg::REG_AW-1:0]    paddr,
  input  logic [scb_pkg::APB_DW-1:0]    pwdata,
  output logic [scb_pkg::APB_DW-1:0]    prdata,
  output logic                          pready,
  // Request channel
  input  logic                          start,
  output logic                          busy,
  input  logic [scb_pkg::ACT_W-1:0]     action,
  input  logic [scb_pkg::SADDR_W-1:0]   sheet_address,
  input  logic [scb_pkg::PIX_W-1:0]     pixel_color,
  input  logic [scb_pkg::SHT_W-1:0]     frame_width,
  input  logic [scb_pkg::SHT_W-1:0]     frame_height,
  input  logic [scb_pkg::IDX_W-1:0]     frame_index,
  input  logic signed [scb_pkg::VPOS_W-1:0] view_x,
  input  logic signed [scb_pkg::VPOS_W-1:0] view_y,
  input  logic                          mirror_x,
  input  logic                          mirror_y,
  // Result channel
  output logic                          result_strobe,
  output logic                          write_enable,
  output logic [scb_pkg::TADDR_W-1:0]   target_address,
  output logic [scb_pkg::COLOR_W-1:0]   color_out,
  output logic [scb_pkg::STAT_W-1:0]    status,
  output logic                          cell_done,
  output logic                          last
);

  import scb_pkg::*;

  localparam int SHEET_AW = $clog2(SHEET_WORDS);
  localparam int DIM_W    = $clog2(MAX_TARGET_DIM + 1);
  localparam int RB_W     = 2 * DIM_W;

  state_t state;

  // Configuration registers
  logic [SHT_W-1:0] sheet_width, sheet_height;
  logic [TGT_W-1:0] target_width, target_height;
  logic [SCL_W-1:0] pixel_scale;

  // Pending start request
  logic [SHT_W-1:0]        pend_fw, pend_fh;
  logic [IDX_W-1:0]        pend_idx;
  logic signed [VPOS_W-1:0] pend_vx, pend_vy;
  logic                    pend_mx, pend_my;
  logic [SHT_W-1:0]        cols, rows;
  logic [PROD_W-1:0]       cell_count;

  // Committed cell and walk state
  logic                    cell_active;
  logic [SHT_W-1:0]        walk_col, walk_row;
  logic [SHT_W-1:0]        origin_x, origin_y;
  logic [SHT_W-1:0]        cell_fw, cell_fh;
  logic signed [VPOS_W-1:0] cell_vx, cell_vy;
  logic                    cell_mx, cell_my;

  // Shared divider
  logic [IDX_W-1:0]   div_num;
  logic [SHT_W-1:0]   div_den, div_rem;
  logic [DCNT_W-1:0]  div_cnt;
  logic [SHT_W:0]     div_shift;
  logic [SHT_W+1:0]   div_diff;
  logic               div_ge, div_last;
  logic [SHT_W-1:0]   div_rem_step;
  logic [IDX_W-1:0]   div_num_step;

  // Advance pipeline
  logic [SHT_W-1:0]         adv_x, adv_y;
  logic [SPOS_W-1:0]        adv_sx, adv_sy;
  logic                     adv_done;
  logic [LIN_W-1:0]         lin;
  logic                     in_sheet;
  logic signed [CRD_W-1:0]  bx0, by0;
  logic [DIM_W-1:0]         clip_x_lo, clip_x_last, clip_y_lo, clip_y_last;
  logic                     clip_hit;
  logic [DIM_W-1:0]         emit_px, emit_py;
  logic [RB_W-1:0]          row_base;
  logic [PIX_W-1:0]         pix_color;

  // Combinational helpers
  logic                     item_acc, cfg_wr;
  logic [REG_IW-1:0]        reg_idx;
  logic [SHT_W:0]           walk_col_inc, walk_row_inc;
  logic                     col_wrap, row_wrap;
  logic [SHT_W-1:0]         off_x, off_y;
  logic [SPOS_W-1:0]        src_x, src_y;
  logic [SCL_W-1:0]         scl;
  logic signed [CRD_W-1:0]  scl_s, vx_sum, vy_sum, bx0_calc, by0_calc;
  logic [LIN_W-1:0]         lin_calc;
  logic                     in_sheet_calc;
  logic [DIM_W-1:0]         tw_eff, th_eff;
  logic signed [CRD_W-1:0]  tw_s, th_s, xend, yend, xlo_s, ylo_s, xhi_s, yhi_s;
  logic signed [CRD_W-1:0]  xlast_s, ylast_s;
  logic [PROD_W-1:0]        count_calc, org_x_full;
  logic [IDX_W+SHT_W-1:0]   org_y_full;
  logic                     draw;
  logic                     emit_row_end, emit_end;

  // Sheet RAM ports
  logic                     ram_we, ram_re;
  logic [LIN_W-1:0]         load_lin;
  logic [PIX_W-1:0]         ram_rdata;

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[REG_AW-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      sheet_width   <= SHEET_W_RST;
      sheet_height  <= SHEET_H_RST;
      target_width  <= TARGET_W_RST;
      target_height <= TARGET_H_RST;
      pixel_scale   <= SCALE_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_SHEET_W:  sheet_width   <= pwdata[SHT_W-1:0];
        REG_SHEET_H:  sheet_height  <= pwdata[SHT_W-1:0];
        REG_TARGET_W: target_width  <= pwdata[TGT_W-1:0];
        REG_TARGET_H: target_height <= pwdata[TGT_W-1:0];
        REG_SCALE:    pixel_scale   <= pwdata[SCL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SHEET_W:  prdata = APB_DW'(sheet_width);
      REG_SHEET_H:  prdata = APB_DW'(sheet_height);
      REG_TARGET_W: prdata = APB_DW'(target_width);
      REG_TARGET_H: prdata = APB_DW'(target_height);
      REG_SCALE:    prdata = APB_DW'(pixel_scale);
      default:      prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sheet RAM: loads only in idle, reads only in S_READ, so no overlap
  // --------------------------------------------------------------------------
  assign busy     = rst || (state != S_IDLE);
  assign item_acc = start && !busy;
  assign load_lin = LIN_W'(sheet_address);
  assign ram_we   = item_acc && (action == ACT_LOAD) && (32'(load_lin) < 32'(SHEET_WORDS));
  assign ram_re   = (state == S_READ) && in_sheet;

  scb_ram #(
    .WIDTH (PIX_W),
    .DEPTH (SHEET_WORDS)
  ) u_sheet_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (load_lin[SHEET_AW-1:0]),
    .wdata (pixel_color),
    .re    (ram_re),
    .raddr (lin[SHEET_AW-1:0]),
    .rdata (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // Restoring divider step, one quotient bit per cycle
  // --------------------------------------------------------------------------
  assign div_shift    = {div_rem, div_num[IDX_W-1]};
  assign div_diff     = {1'b0, div_shift} - {2'b00, div_den};
  assign div_ge       = !div_diff[SHT_W+1];
  assign div_rem_step = div_ge ? div_diff[SHT_W-1:0] : div_shift[SHT_W-1:0];
  assign div_num_step = {div_num[IDX_W-2:0], div_ge};
  assign div_last     = (div_cnt == '1);

  // --------------------------------------------------------------------------
  // Walk step and source coordinate with mirroring
  // --------------------------------------------------------------------------
  assign walk_col_inc = {1'b0, walk_col} + (SHT_W+1)'(1);
  assign walk_row_inc = {1'b0, walk_row} + (SHT_W+1)'(1);
  assign col_wrap     = walk_col_inc >= {1'b0, cell_fw};
  assign row_wrap     = walk_row_inc >= {1'b0, cell_fh};
  assign off_x        = cell_mx ? (cell_fw - SHT_W'(1) - walk_col) : walk_col;
  assign off_y        = cell_my ? (cell_fh - SHT_W'(1) - walk_row) : walk_row;
  assign src_x        = {1'b0, origin_x} + {1'b0, off_x};
  assign src_y        = {1'b0, origin_y} + {1'b0, off_y};

  // --------------------------------------------------------------------------
  // Sheet address and scaled block origin
  // --------------------------------------------------------------------------
  always_comb begin
    if (pixel_scale == '0) begin
      scl = SCL_W'(1);
    end else if (32'(pixel_scale) > 32'(MAX_SCALE)) begin
      scl = SCL_W'(MAX_SCALE);
    end else begin
      scl = pixel_scale;
    end
  end

  assign scl_s    = CRD_W'($signed({1'b0, scl}));
  assign vx_sum   = CRD_W'(cell_vx) + CRD_W'($signed({1'b0, adv_x}));
  assign vy_sum   = CRD_W'(cell_vy) + CRD_W'($signed({1'b0, adv_y}));
  assign bx0_calc = vx_sum * scl_s;
  assign by0_calc = vy_sum * scl_s;

  assign lin_calc = LIN_W'(adv_sy) * LIN_W'(sheet_width) + LIN_W'(adv_sx);
  assign in_sheet_calc = (adv_sx < {1'b0, sheet_width}) && (adv_sy < {1'b0, sheet_height})
                         && (32'(lin_calc) < 32'(SHEET_WORDS));

  // --------------------------------------------------------------------------
  // Clip the scaled block to the target
  // --------------------------------------------------------------------------
  assign tw_eff = (32'(target_width) > 32'(MAX_TARGET_DIM)) ? DIM_W'(MAX_TARGET_DIM)
                                                            : DIM_W'(target_width);
  assign th_eff = (32'(target_height) > 32'(MAX_TARGET_DIM)) ? DIM_W'(MAX_TARGET_DIM)
                                                             : DIM_W'(target_height);
  assign tw_s    = CRD_W'($signed({1'b0, tw_eff}));
  assign th_s    = CRD_W'($signed({1'b0, th_eff}));
  assign xend    = bx0 + scl_s;
  assign yend    = by0 + scl_s;
  assign xlo_s   = (bx0 < 0) ? '0 : bx0;
  assign ylo_s   = (by0 < 0) ? '0 : by0;
  assign xhi_s   = (xend < tw_s) ? xend : tw_s;
  assign yhi_s   = (yend < th_s) ? yend : th_s;
  assign xlast_s = xhi_s - CRD_W'(1);
  assign ylast_s = yhi_s - CRD_W'(1);

  // Start-side products
  assign count_calc = PROD_W'(cols) * PROD_W'(rows);
  assign org_x_full = PROD_W'(div_rem) * PROD_W'(pend_fw);
  assign org_y_full = (IDX_W+SHT_W)'(div_num) * (IDX_W+SHT_W)'(pend_fh);

  // Emission control
  assign draw         = in_sheet && (ram_rdata != '0) && clip_hit;
  assign emit_row_end = (emit_px == clip_x_last);
  assign emit_end     = emit_row_end && (emit_py == clip_y_last);

  // --------------------------------------------------------------------------
  // Sequencer, cell state and result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      cell_active   <= 1'b0;
      walk_col      <= '0;
      walk_row      <= '0;
      origin_x      <= '0;
      origin_y      <= '0;
      cell_fw       <= '0;
      cell_fh       <= '0;
      cell_vx       <= '0;
      cell_vy       <= '0;
      cell_mx       <= 1'b0;
      cell_my       <= 1'b0;
      div_cnt       <= '0;
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= 1'b0;
      case (state)
        S_IDLE: begin
          if (item_acc) begin
            case (action)
              ACT_START: begin
                pend_fw  <= frame_width;
                pend_fh  <= frame_height;
                pend_idx <= frame_index;
                pend_vx  <= view_x;
                pend_vy  <= view_y;
                pend_mx  <= mirror_x;
                pend_my  <= mirror_y;
                if (frame_width == '0 || frame_height == '0) begin
                  result_strobe  <= 1'b1;
                  write_enable   <= 1'b0;
                  target_address <= '0;
                  color_out      <= '0;
                  status         <= ST_REJECT;
                  cell_done      <= 1'b0;
                  last           <= 1'b1;
                end else begin
                  div_num <= IDX_W'(sheet_width);
                  div_den <= frame_width;
                  div_rem <= '0;
                  div_cnt <= '0;
                  state   <= S_DIVW;
                end
              end
              ACT_ADVANCE: begin
                if (!cell_active) begin
                  result_strobe  <= 1'b1;
                  write_enable   <= 1'b0;
                  target_address <= '0;
                  color_out      <= '0;
                  status         <= ST_NO_CELL;
                  cell_done      <= 1'b0;
                  last           <= 1'b1;
                end else begin
                  adv_x    <= walk_col;
                  adv_y    <= walk_row;
                  adv_sx   <= src_x;
                  adv_sy   <= src_y;
                  adv_done <= 1'b0;
                  if (col_wrap) begin
                    walk_col <= '0;
                    if (row_wrap) begin
                      walk_row    <= '0;
                      cell_active <= 1'b0;
                      adv_done    <= 1'b1;
                    end else begin
                      walk_row <= walk_row_inc[SHT_W-1:0];
                    end
                  end else begin
                    walk_col <= walk_col_inc[SHT_W-1:0];
                  end
                  state <= S_ADDR;
                end
              end
              default: ;
            endcase
          end
        end

        // columns = sheet_width / frame_width
        S_DIVW: begin
          div_num <= div_num_step;
          div_rem <= div_rem_step;
          div_cnt <= div_cnt + DCNT_W'(1);
          if (div_last) begin
            cols    <= div_num_step[SHT_W-1:0];
            div_num <= IDX_W'(sheet_height);
            div_den <= pend_fh;
            div_rem <= '0;
            state   <= S_DIVH;
          end
        end

        // rows = sheet_height / frame_height
        S_DIVH: begin
          div_num <= div_num_step;
          div_rem <= div_rem_step;
          div_cnt <= div_cnt + DCNT_W'(1);
          if (div_last) begin
            rows  <= div_num_step[SHT_W-1:0];
            state <= S_CHK;
          end
        end

        // No whole cell fits: reject
        S_CHK: begin
          if (cols == '0 || rows == '0) begin
            result_strobe  <= 1'b1;
            write_enable   <= 1'b0;
            target_address <= '0;
            color_out      <= '0;
            status         <= ST_REJECT;
            cell_done      <= 1'b0;
            last           <= 1'b1;
            state          <= S_IDLE;
          end else begin
            cell_count <= count_calc;
            state      <= S_CHK2;
          end
        end

        // Index beyond the sheet: reject, else split index into row/column
        S_CHK2: begin
          if (PROD_W'(pend_idx) >= cell_count) begin
            result_strobe  <= 1'b1;
            write_enable   <= 1'b0;
            target_address <= '0;
            color_out      <= '0;
            status         <= ST_REJECT;
            cell_done      <= 1'b0;
            last           <= 1'b1;
            state          <= S_IDLE;
          end else begin
            div_num <= pend_idx;
            div_den <= cols;
            div_rem <= '0;
            div_cnt <= '0;
            state   <= S_DIVI;
          end
        end

        S_DIVI: begin
          div_num <= div_num_step;
          div_rem <= div_rem_step;
          div_cnt <= div_cnt + DCNT_W'(1);
          if (div_last) begin
            state <= S_ORG;
          end
        end

        // Commit the new cell; origins stay inside the sheet
        S_ORG: begin
          origin_x       <= org_x_full[SHT_W-1:0];
          origin_y       <= org_y_full[SHT_W-1:0];
          cell_fw        <= pend_fw;
          cell_fh        <= pend_fh;
          cell_vx        <= pend_vx;
          cell_vy        <= pend_vy;
          cell_mx        <= pend_mx;
          cell_my        <= pend_my;
          walk_col       <= '0;
          walk_row       <= '0;
          cell_active    <= 1'b1;
          result_strobe  <= 1'b1;
          write_enable   <= 1'b0;
          target_address <= '0;
          color_out      <= '0;
          status         <= ST_OK;
          cell_done      <= 1'b0;
          last           <= 1'b1;
          state          <= S_IDLE;
        end

        S_ADDR: begin
          lin      <= lin_calc;
          in_sheet <= in_sheet_calc;
          bx0      <= bx0_calc;
          by0      <= by0_calc;
          state    <= S_READ;
        end

        // RAM read in flight; register the clip window
        S_READ: begin
          clip_x_lo   <= xlo_s[DIM_W-1:0];
          clip_y_lo   <= ylo_s[DIM_W-1:0];
          clip_x_last <= xlast_s[DIM_W-1:0];
          clip_y_last <= ylast_s[DIM_W-1:0];
          clip_hit    <= (xlo_s < xhi_s) && (ylo_s < yhi_s);
          state       <= S_DATA;
        end

        // Transparent, off-sheet or fully clipped: one no-write result
        S_DATA: begin
          if (draw) begin
            pix_color <= ram_rdata;
            row_base  <= RB_W'(clip_y_lo) * RB_W'(tw_eff);
            emit_px   <= clip_x_lo;
            emit_py   <= clip_y_lo;
            state     <= S_EMIT;
          end else begin
            result_strobe  <= 1'b1;
            write_enable   <= 1'b0;
            target_address <= '0;
            color_out      <= '0;
            status         <= ST_OK;
            cell_done      <= adv_done;
            last           <= 1'b1;
            state          <= S_IDLE;
          end
        end

        // One target write per cycle over the clipped square
        S_EMIT: begin
          result_strobe  <= 1'b1;
          write_enable   <= 1'b1;
          target_address <= TADDR_W'(row_base + RB_W'(emit_px));
          color_out      <= ALPHA_OPAQUE | COLOR_W'(pix_color);
          status         <= ST_OK;
          cell_done      <= emit_end && adv_done;
          last           <= emit_end;
          if (emit_row_end) begin
            emit_px  <= clip_x_lo;
            emit_py  <= emit_py + DIM_W'(1);
            row_base <= row_base + RB_W'(tw_eff);
            if (emit_end) begin
              state <= S_IDLE;
            end
          end else begin
            emit_px <= emit_px + DIM_W'(1);
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // A result only follows work in progress or a request taken at idle
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> ($past(busy) || $past(start)))
    else $error("result without a pending request");

  // Cell completion is reported on the final result of a request
  a_done_on_last: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && cell_done) |-> last)
    else $error("cell_done without last");

  // Loads and lookups never share a cycle on the sheet RAM
  a_ram_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(ram_we && ram_re))
    else $error("sheet RAM load collides with a read");

  // Emission stays inside the clip window
  a_emit_in_window: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> ((emit_px <= clip_x_last) && (emit_py <= clip_y_last)))
    else $error("emission outside the clip window");
`endif

endmodule

>>> verif/tb_sprite_cell_blitter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sprite_cell_blitter
// Self-checking bench for the sprite cell blitter. A short directed run
// covers rejects, extremes, mirroring, transparency and clipping. Then six
// register settings follow, each with random cell draws and noise. Every
// accepted request is predicted by a scoreboard, and each result is checked
// field by field in order.
// ----------------------------------------------------------------------------
module tb_sprite_cell_blitter;
  import scb_pkg::*;

  // Undefined action code, dropped by the block
  localparam logic [ACT_W-1:0] ACT_NONE = 2'd3;
  localparam int DRAIN_CYCLES = 80;
  localparam int STORE_WORDS  = SHEET_WORDS_DEF;
  localparam int RANDOM_REQS  = 145;
  localparam int NUM_PHASES   = 6;
  localparam int MAX_LOGGED   = 40;

  typedef struct {
    logic [ACT_W-1:0]          action;
    logic [SADDR_W-1:0]        sheet_address;
    logic [PIX_W-1:0]          pixel_color;
    logic [SHT_W-1:0]          frame_width;
    logic [SHT_W-1:0]          frame_height;
    logic [IDX_W-1:0]          frame_index;
    logic signed [VPOS_W-1:0]  view_x;
    logic signed [VPOS_W-1:0]  view_y;
    logic                      mirror_x;
    logic                      mirror_y;
  } blit_req_t;

  typedef struct {
    logic                 write_enable;
    logic [TADDR_W-1:0]   target_address;
    logic [COLOR_W-1:0]   color_out;
    logic [STAT_W-1:0]    status;
    logic                 cell_done;
    logic                 last;
  } blit_res_t;

  // --------------------------------------------------------------------------
  // Scoreboard: own copy of sheet, registers and walk state
  // --------------------------------------------------------------------------
  class blit_scoreboard;
    blit_res_t                pixel_writes_q[$];
    bit [PIX_W-1:0]           sheet_img[int];
    int                       sheet_w, sheet_h, tgt_w, tgt_h, scale;
    bit                       active;
    int                       walk_col, walk_row, org_x, org_y, cell_w, cell_h;
    logic signed [VPOS_W-1:0] cell_vx, cell_vy;
    bit                       mir_x, mir_y;
    int                       errors;

    function new();
      errors   = 0;
      sheet_w  = SHEET_W_RST;
      sheet_h  = SHEET_H_RST;
      tgt_w    = TARGET_W_RST;
      tgt_h    = TARGET_H_RST;
      scale    = SCALE_RST;
      active   = 0;
      walk_col = 0;
      walk_row = 0;
      org_x    = 0;
      org_y    = 0;
      cell_w   = 0;
      cell_h   = 0;
      cell_vx  = '0;
      cell_vy  = '0;
      mir_x    = 0;
      mir_y    = 0;
    endfunction

    task report_mismatch(string msg);
      errors++;
      if (errors <= MAX_LOGGED) $display("%0t MISMATCH %s", $realtime, msg);
    endtask

    function int pending();
      return pixel_writes_q.size();
    endfunction

    function void set_reg(logic [REG_IW-1:0] idx, int value);
      case (idx)
        REG_SHEET_W:  sheet_w = value & 'h1FF;
        REG_SHEET_H:  sheet_h = value & 'h1FF;
        REG_TARGET_W: tgt_w   = value & 'hFFF;
        REG_TARGET_H: tgt_h   = value & 'hFFF;
        REG_SCALE:    scale   = value & 'hF;
        default: ;
      endcase
    endfunction

    // Sheet word the next advance reads, or -1 when it reads none
    function int source_addr();
      int sx, sy;
      if (!active) return -1;
      sx = org_x + (mir_x ? cell_w - 1 - walk_col : walk_col);
      sy = org_y + (mir_y ? cell_h - 1 - walk_row : walk_row);
      if (sx >= sheet_w || sy >= sheet_h) return -1;
      if (sy * sheet_w + sx >= STORE_WORDS) return -1;
      return sy * sheet_w + sx;
    endfunction

    function void note_request(blit_req_t r);
      blit_res_t        held;
      int               fw, fh, cols, rows, idx, a, x, y, zoom, tw, th;
      int               bx0, by0, px, py, n;
      bit               done;
      bit [PIX_W-1:0]   rgb;
      held = '{1'b0, '0, '0, ST_OK, 1'b0, 1'b1};
      case (r.action)
        ACT_LOAD: sheet_img[int'(r.sheet_address)] = r.pixel_color;
        ACT_START: begin
          fw  = r.frame_width;
          fh  = r.frame_height;
          idx = r.frame_index;
          held.status = ST_REJECT;
          if (fw != 0 && fh != 0) begin
            cols = sheet_w / fw;
            rows = sheet_h / fh;
            if (cols != 0 && rows != 0 && idx < cols * rows) begin
              org_x    = (idx % cols) * fw;
              org_y    = (idx / cols) * fh;
              cell_w   = fw;
              cell_h   = fh;
              cell_vx  = r.view_x;
              cell_vy  = r.view_y;
              mir_x    = r.mirror_x;
              mir_y    = r.mirror_y;
              walk_col = 0;
              walk_row = 0;
              active   = 1;
              held.status = ST_OK;
            end
          end
          pixel_writes_q.push_back(held);
        end
        ACT_ADVANCE: begin
          if (!active) begin
            held.status = ST_NO_CELL;
            pixel_writes_q.push_back(held);
          end else begin
            a    = source_addr();
            x    = walk_col;
            y    = walk_row;
            done = 0;
            // raster walk, cell ends after its last row
            walk_col = x + 1;
            if (walk_col >= cell_w) begin
              walk_col = 0;
              walk_row = y + 1;
              if (walk_row >= cell_h) begin
                walk_row = 0;
                active   = 0;
                done     = 1;
              end
            end
            rgb = (a >= 0 && sheet_img.exists(a)) ? sheet_img[a] : '0;
            n = 0;
            // opaque pixel becomes a clipped square of writes
            if (rgb != 0) begin
              zoom = (scale < 1) ? 1 : ((scale > MAX_SCALE) ? MAX_SCALE : scale);
              tw   = (tgt_w > MAX_TARGET_DIM_DEF) ? MAX_TARGET_DIM_DEF : tgt_w;
              th   = (tgt_h > MAX_TARGET_DIM_DEF) ? MAX_TARGET_DIM_DEF : tgt_h;
              bx0  = (int'(cell_vx) + x) * zoom;
              by0  = (int'(cell_vy) + y) * zoom;
              for (int by = 0; by < zoom; by++) begin
                py = by0 + by;
                if (py >= 0 && py < th) begin
                  for (int bx = 0; bx < zoom; bx++) begin
                    px = bx0 + bx;
                    if (px >= 0 && px < tw) begin
                      if (n > 0) pixel_writes_q.push_back(held);
                      held = '{1'b1, TADDR_W'(py * tw + px), ALPHA_OPAQUE | COLOR_W'(rgb),
                               ST_OK, 1'b0, 1'b0};
                      n++;
                    end
                  end
                end
              end
            end
            held.cell_done = done;
            held.last      = 1'b1;
            pixel_writes_q.push_back(held);
          end
        end
        default: ;
      endcase
    endfunction

    task check_result(blit_res_t got);
      blit_res_t want;
      if (pixel_writes_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result we=%0b addr=%0h color=%h st=%0d",
                                  got.write_enable, got.target_address, got.color_out,
                                  got.status));
      end else begin
        want = pixel_writes_q.pop_front();
        if (got.write_enable !== want.write_enable || got.target_address !== want.target_address ||
            got.color_out !== want.color_out || got.status !== want.status ||
            got.cell_done !== want.cell_done || got.last !== want.last)
          report_mismatch($sformatf(
            "got we=%0b addr=%0h color=%h st=%0d done=%0b last=%0b, want %0b %0h %h %0d %0b %0b",
            got.write_enable, got.target_address, got.color_out, got.status, got.cell_done,
            got.last, want.write_enable, want.target_address, want.color_out, want.status,
            want.cell_done, want.last));
      end
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Signals and block
  // --------------------------------------------------------------------------
  logic                     clk = 1'b0;
  logic                     rst;
  logic                     psel, penable, pwrite, pready;
  logic [REG_AW-1:0]        paddr;
  logic [APB_DW-1:0]        pwdata, prdata;
  logic                     start, busy;
  logic [ACT_W-1:0]         action;
  logic [SADDR_W-1:0]       sheet_address;
  logic [PIX_W-1:0]         pixel_color;
  logic [SHT_W-1:0]         frame_width, frame_height;
  logic [IDX_W-1:0]         frame_index;
  logic signed [VPOS_W-1:0] view_x, view_y;
  logic                     mirror_x, mirror_y;
  logic                     result_strobe, write_enable, cell_done, last;
  logic [TADDR_W-1:0]       target_address;
  logic [COLOR_W-1:0]       color_out;
  logic [STAT_W-1:0]        status;

  blit_scoreboard sb;
  int             reqs_sent;
  bit             idle_on;

  // register settings per random phase: typical, smallest, largest, odd
  int phase_sheet_w [NUM_PHASES] = '{16, 1, 256, 255, 100, 64};
  int phase_sheet_h [NUM_PHASES] = '{12, 1, 256, 7, 64, 64};
  int phase_tgt_w   [NUM_PHASES] = '{40, 1, 2048, 2047, 1, 320};
  int phase_tgt_h   [NUM_PHASES] = '{30, 1, 2048, 5, 2048, 240};
  int phase_scale   [NUM_PHASES] = '{3, 8, 8, 2, 1, 2};

  sprite_cell_blitter dut (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .start          (start),
    .busy           (busy),
    .action         (action),
    .sheet_address  (sheet_address),
    .pixel_color    (pixel_color),
    .frame_width    (frame_width),
    .frame_height   (frame_height),
    .frame_index    (frame_index),
    .view_x         (view_x),
    .view_y         (view_y),
    .mirror_x       (mirror_x),
    .mirror_y       (mirror_y),
    .result_strobe  (result_strobe),
    .write_enable   (write_enable),
    .target_address (target_address),
    .color_out      (color_out),
    .status         (status),
    .cell_done      (cell_done),
    .last           (last)
  );

  always #5 clk = ~clk;

  // Result monitor
  always @(posedge clk) begin
    blit_res_t got;
    if (!rst && result_strobe) begin
      got.write_enable   = write_enable;
      got.target_address = target_address;
      got.color_out      = color_out;
      got.status         = status;
      got.cell_done      = cell_done;
      got.last           = last;
      sb.check_result(got);
    end
  end

  // --------------------------------------------------------------------------
  // Request driving
  // --------------------------------------------------------------------------
  function automatic blit_req_t rand_req(logic [ACT_W-1:0] act);
    blit_req_t r;
    r.action        = act;
    r.sheet_address = SADDR_W'($urandom_range(0, 65535));
    r.pixel_color   = PIX_W'($urandom_range(0, 24'hFFFFFF));
    r.frame_width   = SHT_W'($urandom_range(0, 511));
    r.frame_height  = SHT_W'($urandom_range(0, 511));
    r.frame_index   = IDX_W'($urandom_range(0, 65535));
    r.view_x        = VPOS_W'($urandom_range(0, 4095));
    r.view_y        = VPOS_W'($urandom_range(0, 4095));
    r.mirror_x      = 1'($urandom_range(0, 1));
    r.mirror_y      = 1'($urandom_range(0, 1));
    return r;
  endfunction

  // mostly opaque, some transparent black, some full white
  function automatic logic [PIX_W-1:0] pick_color();
    case ($urandom_range(0, 7))
      0, 1:    return '0;
      2:       return 24'hFFFFFF;
      default: return PIX_W'($urandom_range(1, 24'hFFFFFF));
    endcase
  endfunction

  // view coordinate straddling either edge of the target, inside, or anywhere
  function automatic logic signed [VPOS_W-1:0] pick_view(int span, int cell_len);
    int v;
    case ($urandom_range(0, 3))
      0:       v = int'($urandom_range(0, 4095)) - 2048;
      1:       v = int'($urandom_range(0, cell_len + 1)) - cell_len;
      2:       v = span - int'($urandom_range(0, cell_len + 1));
      default: v = int'($urandom_range(0, span));
    endcase
    if (v > 2047) v = 2047;
    if (v < -2048) v = -2048;
    return v[VPOS_W-1:0];
  endfunction

  task automatic pause(int n);
    @(negedge clk) start <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // hold the request until the block takes it
  task automatic send_req(blit_req_t r);
    @(negedge clk);
    start         <= 1'b1;
    action        <= r.action;
    sheet_address <= r.sheet_address;
    pixel_color   <= r.pixel_color;
    frame_width   <= r.frame_width;
    frame_height  <= r.frame_height;
    frame_index   <= r.frame_index;
    view_x        <= r.view_x;
    view_y        <= r.view_y;
    mirror_x      <= r.mirror_x;
    mirror_y      <= r.mirror_y;
    do @(posedge clk); while (busy);
    sb.note_request(r);
    if (r.action != ACT_NONE) reqs_sent++;
    if (idle_on && $urandom_range(0, 2) == 0) pause($urandom_range(1, 18));
  endtask

  task automatic load_px(int addr, logic [PIX_W-1:0] rgb);
    blit_req_t r;
    r = rand_req(ACT_LOAD);
    r.sheet_address = SADDR_W'(addr);
    r.pixel_color   = rgb;
    send_req(r);
  endtask

  task automatic start_cell(int fw, int fh, int idx, int vx, int vy, int mx, int my);
    blit_req_t r;
    r = rand_req(ACT_START);
    r.frame_width  = SHT_W'(fw);
    r.frame_height = SHT_W'(fh);
    r.frame_index  = IDX_W'(idx);
    r.view_x       = VPOS_W'(vx);
    r.view_y       = VPOS_W'(vy);
    r.mirror_x     = 1'(mx);
    r.mirror_y     = 1'(my);
    send_req(r);
  endtask

  // never let an advance read a sheet word that was not loaded
  task automatic advance_px();
    int a;
    a = sb.source_addr();
    if (a >= 0 && !sb.sheet_img.exists(a)) load_px(a, pick_color());
    send_req(rand_req(ACT_ADVANCE));
  endtask

  // Well-formed draw: load the cell, start it, walk it (sometimes cut short)
  task automatic run_cell_sequence();
    int  fw, fh, cols, rows, idx, ox, oy, a, steps, zoom;
    bit  wide;
    wide = ($urandom_range(0, 9) == 0);
    if (wide) begin
      fw = sb.sheet_w;
      fh = 1;
    end else begin
      fw = $urandom_range(1, (sb.sheet_w < 6) ? sb.sheet_w : 6);
      fh = $urandom_range(1, (sb.sheet_h < 16 / fw) ? sb.sheet_h : 16 / fw);
    end
    cols = sb.sheet_w / fw;
    rows = sb.sheet_h / fh;
    idx  = $urandom_range(0, cols * rows - 1);
    ox   = (idx % cols) * fw;
    oy   = (idx / cols) * fh;
    if (!wide) begin
      for (int row = 0; row < fh; row++) begin
        for (int col = 0; col < fw; col++) begin
          a = (oy + row) * sb.sheet_w + ox + col;
          if (!sb.sheet_img.exists(a) || $urandom_range(0, 1)) load_px(a, pick_color());
        end
      end
    end
    zoom = (sb.scale < 1) ? 1 : sb.scale;
    start_cell(fw, fh, idx, int'(pick_view(sb.tgt_w / zoom, fw)),
               int'(pick_view(sb.tgt_h / zoom, fh)),
               int'($urandom_range(0, 1)), int'($urandom_range(0, 1)));
    steps = wide ? ((fw < 10) ? fw : 10) : fw * fh;
    for (int i = 0; i < steps; i++) begin
      if ($urandom_range(0, 19) == 0) break;
      advance_px();
    end
    if ($urandom_range(0, 3) == 0) advance_px();
  endtask

  // Noise: odd starts, stray advances, random loads, undefined action
  task automatic run_noise();
    blit_req_t r;
    int        fw, fh;
    case ($urandom_range(0, 4))
      0: send_req(rand_req(ACT_START));
      1: advance_px();
      2: send_req(rand_req(ACT_LOAD));
      3: send_req(rand_req(ACT_NONE));
      default: begin
        // cell index at the last cell or right at the sheet's cell count
        fw = $urandom_range(1, sb.sheet_w);
        fh = $urandom_range(1, sb.sheet_h);
        r  = rand_req(ACT_START);
        r.frame_width  = SHT_W'(fw);
        r.frame_height = SHT_W'(fh);
        r.frame_index  = IDX_W'((sb.sheet_w / fw) * (sb.sheet_h / fh) - 1 +
                                int'($urandom_range(0, 1)));
        send_req(r);
      end
    endcase
  endtask

  // wait until every expected result has come, then let the pipe empty
  task automatic quiesce();
    @(negedge clk) start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // APB write then read back
  task automatic write_reg(logic [REG_IW-1:0] idx, int value);
    logic [APB_DW-1:0] rd;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk) penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, value);
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk) penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd !== APB_DW'(value))
      sb.report_mismatch($sformatf("register %0d reads %0h, wrote %0h", idx, rd, value));
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int base;
    sb            = new();
    reqs_sent     = 0;
    idle_on       = 1'b0;
    rst           = 1'b1;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    start         = 1'b0;
    action        = ACT_LOAD;
    sheet_address = '0;
    pixel_color   = '0;
    frame_width   = '0;
    frame_height  = '0;
    frame_index   = '0;
    view_x        = '0;
    view_y        = '0;
    mirror_x      = 1'b0;
    mirror_y      = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // Directed part at reset settings
    advance_px();                              // no cell armed
    send_req(rand_req(ACT_NONE));
    start_cell(0, 5, 0, 0, 0, 0, 0);           // zero width
    start_cell(4, 0, 0, 0, 0, 0, 0);           // zero height
    start_cell(511, 1, 0, 0, 0, 0, 0);         // wider than the sheet
    start_cell(256, 256, 1, 0, 0, 0, 0);       // index past last cell
    load_px(65535, 24'hFFFFFF);
    start_cell(1, 1, 65535, 5, 3, 0, 0);       // last cell of the sheet
    advance_px();
    load_px(0, 24'h000001);
    start_cell(1, 1, 0, -2048, -2048, 0, 0);   // fully clipped
    advance_px();
    load_px(1, '0);
    load_px(256, 24'h123456);
    load_px(257, 24'h800000);
    start_cell(2, 2, 0, 0, 0, 1, 1);           // both mirrors, one transparent pixel
    repeat (5) advance_px();
    start_cell(2, 2, 0, -1, 719, 0, 0);        // edge straddle, then replaced
    advance_px();
    start_cell(1, 1, 0, 2047, 2047, 1, 0);
    advance_px();

    // Random phases, one register setting each
    base = reqs_sent;
    for (int p = 0; p < NUM_PHASES; p++) begin
      quiesce();
      write_reg(REG_SHEET_W, phase_sheet_w[p]);
      write_reg(REG_SHEET_H, phase_sheet_h[p]);
      write_reg(REG_TARGET_W, phase_tgt_w[p]);
      write_reg(REG_TARGET_H, phase_tgt_h[p]);
      write_reg(REG_SCALE, phase_scale[p]);
      while (reqs_sent < base + RANDOM_REQS * (p + 1) / NUM_PHASES) begin
        idle_on = (p != NUM_PHASES - 1) && ($urandom_range(0, 3) != 0);
        if ($urandom_range(0, 9) < 7) run_cell_sequence();
        else run_noise();
      end
    end

    quiesce();
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
